// File: rtl/spcf_pkg.sv
// ----------------------------------------------------------------------------
// spcf_pkg
// Shared types, codes and helpers of the softened potential center finder.
// ----------------------------------------------------------------------------
package spcf_pkg;

  localparam int MAX_PART = 4096;
  localparam int CNT_W    = 13;
  localparam int ADDR_W   = 12;

  // operation codes of the shared arithmetic unit
  localparam logic [1:0] OP_DIV  = 2'd0;
  localparam logic [1:0] OP_SQRT = 2'd1;
  localparam logic [1:0] OP_MUL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_BOX  = 2'd0;
  localparam logic [1:0] REG_SOFT = 2'd1;
  localparam logic [1:0] REG_MASS = 2'd2;
  localparam logic [1:0] REG_GID  = 2'd3;

  // one saturated potential term, 2^48
  localparam logic [63:0] POT_ONE = 64'h0001_0000_0000_0000;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } spcf_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } spcf_stat_t;

  // unsigned 64-bit add that sticks at all ones
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

// File: rtl/softened_potential_center_finder_core.sv
// ----------------------------------------------------------------------------
// softened_potential_center_finder_core
// Loads a group of particles, finds the deepest softened potential particle
// and reports mean velocity and dispersion once per group.
// ----------------------------------------------------------------------------
// Loading: three divide and three multiply passes per particle of the shared
//   64-step arithmetic unit for the running variance.
// Closing word: one square root of the shared unit per ordered pair, and one
//   divide unless the root is zero, then the result is registered.
// The shared arithmetic unit and the single position memory read port set the pace.
// Reset (synchronous, rst_n low) clears counters and sums; positions need none.
// ----------------------------------------------------------------------------
module softened_potential_center_finder_core import spcf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // input words
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  logic         in_tlast,   // last
  // result words
  output logic         out_tvalid,
  input  logic         out_tready,
  // group_id, particle_count, total mass, center_x, center_y, center_z,
  // mean_vx, mean_vy, mean_vz, vel_dispersion, 3 zero bits
  output logic [319:0] out_tdata,
  output logic         out_tuser,  // box wrap flag
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_W_GO  = 5'd1;
  localparam logic [4:0] S_W_DWT = 5'd2;
  localparam logic [4:0] S_W_MGO = 5'd3;
  localparam logic [4:0] S_W_MWT = 5'd4;
  localparam logic [4:0] S_T_GO  = 5'd5;
  localparam logic [4:0] S_T_WT  = 5'd6;
  localparam logic [4:0] S_J_CHK = 5'd7;
  localparam logic [4:0] S_RD_I  = 5'd8;
  localparam logic [4:0] S_RD_J  = 5'd9;
  localparam logic [4:0] S_RD_W  = 5'd10;
  localparam logic [4:0] S_DIFF  = 5'd11;
  localparam logic [4:0] S_SQ    = 5'd12;
  localparam logic [4:0] S_SR_GO = 5'd13;
  localparam logic [4:0] S_SR_WT = 5'd14;
  localparam logic [4:0] S_DV_GO = 5'd15;
  localparam logic [4:0] S_DV_WT = 5'd16;
  localparam logic [4:0] S_C_RD  = 5'd17;
  localparam logic [4:0] S_C_LAT = 5'd18;
  localparam logic [4:0] S_V_GO  = 5'd19;
  localparam logic [4:0] S_V_WT  = 5'd20;
  localparam logic [4:0] S_V2_GO = 5'd21;
  localparam logic [4:0] S_V2_WT = 5'd22;
  localparam logic [4:0] S_Q_GO  = 5'd23;
  localparam logic [4:0] S_Q_WT  = 5'd24;
  localparam logic [4:0] S_OUT   = 5'd25;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PART);

  // ceil(2^34 / 5): box / 5 is the product shifted down by 34
  localparam logic [63:0] DIV5_RECIP = 64'h0000_0000_CCCC_CCCD;

  // configuration registers
  logic [30:0] box_r, soft_r, pmass_r, fgid_r;

  // sequencer and group state
  logic [4:0]        state_r;
  logic [31:0]       vel_r [3];
  logic              last_r;
  logic [CNT_W-1:0]  loaded_r;
  logic [47:0]       mean_r [3];
  logic [63:0]       ssum_r [3];
  logic [31:0]       groups_r;
  logic [1:0]        k_r;
  logic [48:0]       mag_r;
  logic [30:0]       thr_r;
  logic [63:0]       eps2_r;
  logic [CNT_W-1:0]  i_r, j_r;
  logic [63:0]       pot_r, best_r, s_r;
  logic [ADDR_W-1:0] center_r;
  logic              wrap_r;
  logic [30:0]       dmag_r;
  logic [95:0]       pi_r, rd_q_r, cpos_r;
  logic [47:0]       qv_r;
  logic [31:0]       disp_r;

  // output register
  logic         out_tvalid_r;
  logic [319:0] out_tdata_r;
  logic         out_tuser_r;

  // position memory
  logic [95:0]       pos_mem [MAX_PART];
  logic [ADDR_W-1:0] rd_addr;

  // shared unit
  spcf_req_t   ureq;
  spcf_stat_t  ustat;
  logic [63:0] ua, ub, ures, uaux;

  spcf_arith_unit u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ureq),
    .a_i   (ua),
    .b_i   (ub),
    .stat  (ustat),
    .res   (ures),
    .aux   (uaux)
  );

  logic in_acc, cfg_wr, out_free;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free  = !out_tvalid_r || out_tready;

  // running variance terms for the current axis
  logic [47:0] v_k, mean_k, mean_new;
  logic [49:0] del, e_d;
  logic [48:0] mag, e_mag;
  logic [63:0] w_term;
  always_comb begin
    v_k      = {vel_r[k_r], 16'd0};
    mean_k   = mean_r[k_r];
    del      = {{2{v_k[47]}}, v_k} - {{2{mean_k[47]}}, mean_k};
    mag      = del[49] ? 49'(-del) : del[48:0];
    mean_new = del[49] ? (mean_k - ures[47:0]) : (mean_k + ures[47:0]);
    e_d      = {{2{v_k[47]}}, v_k} - {{2{mean_k[47]}}, mean_k};
    e_mag    = e_d[49] ? 49'(-e_d) : e_d[48:0];
    w_term   = {uaux[47:0], ures[63:48]};
  end

  // wrapped and clamped axis difference of the current pair
  logic [31:0] pa [3];
  logic [31:0] pb [3];
  logic signed [34:0] dd, dw, thr_s, box_s;
  logic              dwrap;
  logic [34:0]       dabs;
  logic [30:0]       dmag;
  assign pa[0] = pi_r[31:0];
  assign pa[1] = pi_r[63:32];
  assign pa[2] = pi_r[95:64];
  assign pb[0] = rd_q_r[31:0];
  assign pb[1] = rd_q_r[63:32];
  assign pb[2] = rd_q_r[95:64];
  always_comb begin
    thr_s = $signed({4'd0, thr_r});
    box_s = $signed({4'd0, box_r});
    dd    = $signed({{3{pa[k_r][31]}}, pa[k_r]}) - $signed({{3{pb[k_r][31]}}, pb[k_r]});
    dwrap = 1'b1;
    priority if (dd > thr_s) begin
      dw = dd - box_s;
    end else if (dd < -thr_s) begin
      dw = dd + box_s;
    end else begin
      dw    = dd;
      dwrap = 1'b0;
    end
    dabs = dw[34] ? 35'(-dw) : 35'(dw);
    dmag = (dabs > 35'h7FFF_FFFF) ? 31'h7FFF_FFFF : dabs[30:0];
  end

  // unit request and memory read address
  always_comb begin
    ureq = '{start: 1'b0, op: OP_DIV};
    ua   = '0;
    ub   = '0;
    unique case (state_r)
      S_W_GO: begin
        ureq = '{start: 1'b1, op: OP_DIV};
        ua   = {15'd0, mag};
        ub   = {51'd0, loaded_r + CNT_W'(1)};
      end
      S_W_MGO: begin
        ureq = '{start: 1'b1, op: OP_MUL};
        ua   = {15'd0, mag_r};
        ub   = {15'd0, e_mag};
      end
      S_T_GO: begin
        ureq = '{start: 1'b1, op: OP_MUL};
        ua   = {33'd0, box_r};
        ub   = DIV5_RECIP;
      end
      S_SR_GO: begin
        ureq = '{start: 1'b1, op: OP_SQRT};
        ua   = s_r;
      end
      S_DV_GO: begin
        ureq = '{start: 1'b1, op: OP_DIV};
        ua   = POT_ONE;
        ub   = ures;
      end
      S_V_GO: begin
        ureq = '{start: 1'b1, op: OP_DIV};
        ua   = sat_add64(sat_add64(ssum_r[0], ssum_r[1]), ssum_r[2]);
        ub   = {51'd0, loaded_r};
      end
      S_V2_GO: begin
        ureq = '{start: 1'b1, op: OP_DIV};
        ua   = {uaux[47:0], 16'd0};
        ub   = {51'd0, loaded_r};
      end
      S_Q_GO: begin
        ureq = '{start: 1'b1, op: OP_SQRT};
        ua   = {qv_r, 16'd0} + ures;
      end
      default: begin
        ureq = '{start: 1'b0, op: OP_DIV};
      end
    endcase
    priority case (state_r)
      S_RD_I:  rd_addr = i_r[ADDR_W-1:0];
      S_C_RD:  rd_addr = center_r;
      default: rd_addr = j_r[ADDR_W-1:0];
    endcase
  end

  // position memory ports
  always_ff @(posedge clk) begin
    if (in_acc && loaded_r < MAX_CNT) begin
      pos_mem[loaded_r[ADDR_W-1:0]] <= in_tdata[95:0];
    end
    rd_q_r <= pos_mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r   <= 31'd65536000;
      soft_r  <= 31'd655;
      pmass_r <= 31'd65536;
      fgid_r  <= 31'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_BOX:  box_r   <= cfg_pwdata[30:0];
        REG_SOFT: soft_r  <= cfg_pwdata[30:0];
        REG_MASS: pmass_r <= cfg_pwdata[30:0];
        REG_GID:  fgid_r  <= cfg_pwdata[30:0];
        default:  box_r   <= box_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_BOX:  cfg_prdata = {1'b0, box_r};
      REG_SOFT: cfg_prdata = {1'b0, soft_r};
      REG_MASS: cfg_prdata = {1'b0, pmass_r};
      REG_GID:  cfg_prdata = {1'b0, fgid_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      loaded_r     <= '0;
      groups_r     <= '0;
      out_tvalid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        mean_r[a] <= '0;
        ssum_r[a] <= '0;
      end
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (loaded_r < MAX_CNT) begin
              state_r <= S_W_GO;
            end else if (in_tlast) begin
              state_r <= S_T_GO;
            end
          end
        end
        S_W_GO:  state_r <= S_W_DWT;
        S_W_DWT: begin
          if (ustat.done) begin
            mean_r[k_r] <= mean_new;
            state_r     <= S_W_MGO;
          end
        end
        S_W_MGO: state_r <= S_W_MWT;
        S_W_MWT: begin
          if (ustat.done) begin
            ssum_r[k_r] <= sat_add64(ssum_r[k_r], w_term);
            if (k_r == 2'd2) begin
              loaded_r <= loaded_r + CNT_W'(1);
              state_r  <= last_r ? S_T_GO : S_IDLE;
            end else begin
              state_r <= S_W_GO;
            end
          end
        end
        S_T_GO:  state_r <= S_T_WT;
        S_T_WT:  if (ustat.done) state_r <= S_J_CHK;
        S_J_CHK: begin
          if (j_r == loaded_r) begin
            if (i_r + CNT_W'(1) == loaded_r) state_r <= S_C_RD;
          end else if (j_r != i_r) begin
            state_r <= S_RD_I;
          end
        end
        S_RD_I:  state_r <= S_RD_J;
        S_RD_J:  state_r <= S_RD_W;
        S_RD_W:  state_r <= S_DIFF;
        S_DIFF:  state_r <= S_SQ;
        S_SQ:    state_r <= (k_r == 2'd2) ? S_SR_GO : S_DIFF;
        S_SR_GO: state_r <= S_SR_WT;
        S_SR_WT: begin
          if (ustat.done) state_r <= (ures == 64'd0) ? S_J_CHK : S_DV_GO;
        end
        S_DV_GO: state_r <= S_DV_WT;
        S_DV_WT: if (ustat.done) state_r <= S_J_CHK;
        S_C_RD:  state_r <= S_C_LAT;
        S_C_LAT: state_r <= S_V_GO;
        S_V_GO:  state_r <= S_V_WT;
        S_V_WT: begin
          if (ustat.done) state_r <= (ures >= POT_ONE) ? S_OUT : S_V2_GO;
        end
        S_V2_GO: state_r <= S_V2_WT;
        S_V2_WT: if (ustat.done) state_r <= S_Q_GO;
        S_Q_GO:  state_r <= S_Q_WT;
        S_Q_WT:  if (ustat.done) state_r <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            loaded_r     <= '0;
            groups_r     <= groups_r + 32'd1;
            for (int a = 0; a < 3; a++) begin
              mean_r[a] <= '0;
              ssum_r[a] <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          vel_r[0] <= in_tdata[127:96];
          vel_r[1] <= in_tdata[159:128];
          vel_r[2] <= in_tdata[191:160];
          last_r   <= in_tlast;
          k_r      <= 2'd0;
        end
      end
      S_W_GO:  mag_r <= mag;
      S_W_MWT: if (ustat.done) k_r <= k_r + 2'd1;
      S_T_WT: begin
        if (ustat.done) begin
          thr_r    <= {1'b0, ures[63:34]};
          eps2_r   <= {2'd0, {31'd0, soft_r} * {31'd0, soft_r}};
          i_r      <= '0;
          j_r      <= '0;
          pot_r    <= '0;
          best_r   <= '0;
          center_r <= '0;
          wrap_r   <= 1'b0;
        end
      end
      S_J_CHK: begin
        if (j_r == loaded_r) begin
          if (i_r == '0 || pot_r > best_r) begin
            best_r   <= pot_r;
            center_r <= i_r[ADDR_W-1:0];
          end
          i_r   <= i_r + CNT_W'(1);
          j_r   <= '0;
          pot_r <= '0;
        end else if (j_r == i_r) begin
          j_r <= j_r + CNT_W'(1);
        end
      end
      S_RD_J: pi_r <= rd_q_r;
      S_RD_W: begin
        k_r <= 2'd0;
        s_r <= eps2_r;
      end
      S_DIFF: begin
        dmag_r <= dmag;
        if (dwrap) wrap_r <= 1'b1;
      end
      S_SQ: begin
        s_r <= s_r + {2'd0, {31'd0, dmag_r} * {31'd0, dmag_r}};
        k_r <= k_r + 2'd1;
      end
      S_SR_WT: begin
        if (ustat.done && ures == 64'd0) begin
          pot_r <= sat_add64(pot_r, POT_ONE);
          j_r   <= j_r + CNT_W'(1);
        end
      end
      S_DV_WT: begin
        if (ustat.done) begin
          pot_r <= sat_add64(pot_r, ures);
          j_r   <= j_r + CNT_W'(1);
        end
      end
      S_C_LAT: cpos_r <= rd_q_r;
      S_V_WT: begin
        if (ustat.done) begin
          qv_r   <= ures[47:0];
          disp_r <= 32'hFFFF_FFFF;
        end
      end
      S_Q_WT: if (ustat.done) disp_r <= ures[31:0];
      S_OUT: begin
        if (out_free) begin
          out_tdata_r <= {3'd0, disp_r,
                          mean_r[2][47:16], mean_r[1][47:16], mean_r[0][47:16],
                          cpos_r,
                          4'd0, {13'd0, pmass_r} * {31'd0, loaded_r},
                          loaded_r,
                          32'({1'b0, fgid_r} + groups_r)};
          out_tuser_r <= wrap_r;
        end
      end
      default: begin
        last_r <= last_r;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // checks
  a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ustat.busy)
    else $error("arithmetic unit busy while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= MAX_CNT)
    else $error("particle count beyond store depth");

  a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_tvalid_r && loaded_r == '0))
    else $error("group closed without a result word");

  a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_I) |-> (i_r < loaded_r && j_r < loaded_r && i_r != j_r))
    else $error("pair index out of range");

endmodule

// File: rtl/spcf_arith_unit.sv
// ----------------------------------------------------------------------------
// spcf_arith_unit
// Shared radix-2 unit: 64/64 restoring divide, 64-bit floor square root and
// 64x64 shift-add multiply, one bit (or root digit) per cycle.
// ----------------------------------------------------------------------------
module spcf_arith_unit import spcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  spcf_req_t   req,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output spcf_stat_t  stat,
  output logic [63:0] res,
  output logic [63:0] aux
);

  logic         busy_r;
  logic         done_r;
  logic [1:0]   op_r;
  logic [5:0]   step_r;
  logic [127:0] acc_r;
  logic [63:0]  dvs_r;
  logic [64:0]  rem_r;
  logic [31:0]  root_r;

  logic [64:0]  div_sh, div_d, sq_sh, sq_trial, sq_d, mul_s;
  logic         div_ge, sq_ge;

  // one step of each operation
  always_comb begin
    div_sh   = {rem_r[63:0], acc_r[63]};
    div_ge   = div_sh >= {1'b0, dvs_r};
    div_d    = div_sh - {1'b0, dvs_r};
    sq_sh    = {rem_r[62:0], acc_r[63:62]};
    sq_trial = {31'd0, root_r, 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    sq_d     = sq_sh - sq_trial;
    mul_s    = {1'b0, acc_r[127:64]} + (acc_r[0] ? {1'b0, dvs_r} : 65'd0);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_DIV;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        step_r <= (req.op == OP_SQRT) ? 6'd31 : 6'd63;
      end else if (busy_r) begin
        if (step_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 6'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r  <= {64'd0, a_i};
      dvs_r  <= b_i;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      unique case (op_r)
        OP_DIV: begin
          acc_r[63:0] <= {acc_r[62:0], div_ge};
          rem_r       <= div_ge ? div_d : div_sh;
        end
        OP_SQRT: begin
          acc_r[63:0] <= {acc_r[61:0], 2'b00};
          rem_r       <= sq_ge ? sq_d : sq_sh;
          root_r      <= {root_r[30:0], sq_ge};
        end
        OP_MUL: begin
          acc_r <= {mul_s, acc_r[63:1]};
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign res  = (op_r == OP_SQRT) ? {32'd0, root_r} : acc_r[63:0];
  assign aux  = (op_r == OP_MUL) ? acc_r[127:64] : rem_r[63:0];

endmodule
